// ===== hdl/mpsd_pkg.sv =====
// Shared types, constants and window check for the multiplexed PWM sensor decoder.
`timescale 1ns / 1ps

package mpsd_pkg;

  localparam int TS_W      = 32;
  localparam int CH_W      = 2;
  localparam int WIN_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int OUT_W     = 3 * TS_W;

  typedef enum logic [CH_W-1:0] {
    CH_DIAG  = 2'd0,
    CH_TEMP  = 2'd1,
    CH_PRESS = 2'd2
  } channel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIAG_PERIOD  = 3'd0,
    CFG_DIAG_WIDTH   = 3'd1,
    CFG_TEMP_PERIOD  = 3'd2,
    CFG_TEMP_WIDTH   = 3'd3,
    CFG_PRESS_PERIOD = 3'd4,
    CFG_PRESS_WIDTH  = 3'd5,
    CFG_PKT_LIMIT    = 3'd6
  } cfg_index_t;

  // One edge in flight through the pipeline: tick difference, later microseconds.
  typedef struct packed {
    logic            valid;
    logic            rise;
    logic [TS_W-1:0] value;
  } item_t;

  // Exclusive window: minimum in the low word, maximum in the high word.
  function automatic logic in_window(input logic [TS_W-1:0] v, input logic [WIN_W-1:0] win);
    logic [TS_W-1:0] lo;
    logic [TS_W-1:0] hi;
    lo = win[TS_W-1:0];
    hi = win[WIN_W-1:TS_W];
    return (v > lo) && (v < hi);
  endfunction

endpackage

// ===== hdl/mpsd_tick_div.sv =====
// Registered conversion of a tick count to microseconds by reciprocal multiplication.
`timescale 1ns / 1ps

module mpsd_tick_div #(
  parameter int TICKS_PER_US = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  mpsd_pkg::item_t in_item,
  output mpsd_pkg::item_t out_item
);
  import mpsd_pkg::*;

  // With SHIFT = 32 + ceil(log2(T)) and MULT = ceil(2^SHIFT / T), the top bits of
  // value * MULT are exactly value / T for every 32-bit value.
  localparam int          LOG_T  = $clog2(TICKS_PER_US);
  localparam int          SHIFT  = TS_W + LOG_T;
  localparam int          PROD_W = SHIFT + TS_W;
  localparam logic [63:0] POW    = 64'd1 << SHIFT;
  localparam logic [63:0] MULT   = (POW + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(in_item.value) * PROD_W'(MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item <= '0;
    end else if (en) begin
      out_item.valid <= in_item.valid;
      out_item.rise  <= in_item.rise;
      out_item.value <= prod[SHIFT +: TS_W];
    end
  end

endmodule

// ===== hdl/multiplexed_pwm_sensor_decoder_unit.sv =====
// Top level of the multiplexed PWM sensor decoder: capture stage, slot tracking and result register.
//
//   channel  | dir | tdata (low bit up)                       | tuser
//   s_axis   | in  | timestamp[31:0]                          | edge_rising
//   m_axis   | out | width_us, period_us_out, packet_number   | channel[1:0]
//   cfg      | in  | cfg_we / cfg_index / cfg_data, write only | -
//
// One edge is taken every cycle while the result register is empty or being read;
// each edge passes the difference register and the reciprocal multiplier register
// before its result reaches the result register, which transfers when the receiver is ready.
// All three stages advance together whenever the result register is empty or
// being read, so a stalled output holds every stage in place.
// Reset clears the slot tracking, the counter and the stage valid bits.
`timescale 1ns / 1ps

module multiplexed_pwm_sensor_decoder_unit #(
  parameter int TICKS_PER_US = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mpsd_pkg::TS_W-1:0]      s_axis_tdata,   // timestamp
  input  logic [0:0]                     s_axis_tuser,   // edge_rising
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mpsd_pkg::OUT_W-1:0]     m_axis_tdata,   // width_us, period_us_out, packet_number
  output logic [mpsd_pkg::CH_W-1:0]      m_axis_tuser,   // channel
  input  logic                           cfg_we,
  input  logic [mpsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpsd_pkg::CFG_W-1:0]     cfg_data
);
  import mpsd_pkg::*;

  localparam logic [1:0] SLOT_BAD = 2'd3;

  logic [WIN_W-1:0] diag_period_window;
  logic [WIN_W-1:0] diag_width_window;
  logic [WIN_W-1:0] temp_period_window;
  logic [WIN_W-1:0] temp_width_window;
  logic [WIN_W-1:0] press_period_window;
  logic [WIN_W-1:0] press_width_window;
  logic [TS_W-1:0]  packet_count_limit;

  logic [TS_W-1:0] last_rise_time;
  logic [TS_W-1:0] held_width, held_width_next;
  logic [1:0]      slot_index, slot_index_next;
  logic            synced, synced_next;
  logic [TS_W-1:0] packet_counter, packet_counter_next;

  logic advance;
  logic in_take;
  item_t a_item;
  item_t b_item;

  logic            diag_hit;
  logic            synced_eff;
  logic [1:0]      slot_eff;
  logic            hit;
  channel_t        chan;
  logic [TS_W-1:0] cnt_inc;
  logic [TS_W-1:0] cnt_wrapped;

  channel_t        out_channel;
  logic [TS_W-1:0] out_width;
  logic [TS_W-1:0] out_period;
  logic [TS_W-1:0] out_packet;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_take       = s_axis_tvalid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      diag_period_window  <= '0;
      diag_width_window   <= '0;
      temp_period_window  <= '0;
      temp_width_window   <= '0;
      press_period_window <= '0;
      press_width_window  <= '0;
      packet_count_limit  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIAG_PERIOD:  diag_period_window  <= cfg_data;
        CFG_DIAG_WIDTH:   diag_width_window   <= cfg_data;
        CFG_TEMP_PERIOD:  temp_period_window  <= cfg_data;
        CFG_TEMP_WIDTH:   temp_width_window   <= cfg_data;
        CFG_PRESS_PERIOD: press_period_window <= cfg_data;
        CFG_PRESS_WIDTH:  press_width_window  <= cfg_data;
        CFG_PKT_LIMIT:    packet_count_limit  <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // The tick difference is taken against the previous rising edge as the edge
  // enters, so the reference time can move on in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_rise_time <= '0;
      a_item         <= '0;
    end else begin
      if (in_take && s_axis_tuser[0]) begin
        last_rise_time <= s_axis_tdata;
      end
      if (advance) begin
        a_item.valid <= in_take;
        a_item.rise  <= s_axis_tuser[0];
        a_item.value <= s_axis_tdata - last_rise_time;
      end
    end
  end

  mpsd_tick_div #(
    .TICKS_PER_US(TICKS_PER_US)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .in_item (a_item),
    .out_item(b_item)
  );

  assign cnt_inc     = packet_counter + TS_W'(1);
  assign cnt_wrapped = (cnt_inc > packet_count_limit) ? '0 : cnt_inc;

  always_comb begin
    diag_hit            = in_window(b_item.value, diag_period_window);
    synced_eff          = synced || diag_hit;
    slot_eff            = diag_hit ? 2'd0 : slot_index;
    hit                 = 1'b0;
    chan                = CH_DIAG;
    held_width_next     = held_width;
    slot_index_next     = slot_index;
    synced_next         = synced;
    packet_counter_next = packet_counter;

    if (b_item.valid) begin
      if (!b_item.rise) begin
        held_width_next = b_item.value;
      end else if (synced_eff) begin
        synced_next = 1'b1;
        unique case (slot_eff)
          2'd0: begin
            chan = CH_DIAG;
            hit  = diag_hit && in_window(held_width, diag_width_window);
          end
          2'd1: begin
            chan = CH_TEMP;
            hit  = in_window(b_item.value, temp_period_window)
                && in_window(held_width, temp_width_window);
          end
          2'd2: begin
            chan = CH_PRESS;
            hit  = in_window(b_item.value, press_period_window)
                && in_window(held_width, press_width_window);
            if (hit) begin
              packet_counter_next = cnt_wrapped;
            end
          end
          default: begin
            hit = 1'b0;
          end
        endcase
        // Slot three only arises from a corrupted state; it steps on to slot one.
        unique case (slot_eff)
          2'd0:    slot_index_next = 2'd1;
          2'd1:    slot_index_next = 2'd2;
          2'd2:    slot_index_next = 2'd0;
          default: slot_index_next = 2'd1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_width     <= '0;
      slot_index     <= '0;
      synced         <= 1'b0;
      packet_counter <= '0;
      m_axis_tvalid  <= 1'b0;
    end else if (advance) begin
      held_width     <= held_width_next;
      slot_index     <= slot_index_next;
      synced         <= synced_next;
      packet_counter <= packet_counter_next;
      m_axis_tvalid  <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_channel <= chan;
      out_width   <= held_width;
      out_period  <= b_item.value;
      out_packet  <= packet_counter_next;
    end
  end

  assign m_axis_tdata = {out_packet, out_period, out_width};
  assign m_axis_tuser = out_channel;

`ifndef SYNTHESIS
  a_no_result_unsynced: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> synced)
    else $error("result present while decoder is not synchronized");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_index != SLOT_BAD)
    else $error("slot index reached the unused code");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != SLOT_BAD))
    else $error("result carries an invalid channel");

  a_falling_no_result: assert property (@(posedge clk) disable iff (rst)
    (advance && b_item.valid && !b_item.rise) |=> !m_axis_tvalid)
    else $error("falling edge produced a result");
`endif

endmodule

// ===== sim/multiplexed_pwm_sensor_decoder_unit_test.sv =====
// Self-checking testbench for the multiplexed PWM sensor decoder: edge streams against a predictor.
`timescale 1ns / 1ps

module multiplexed_pwm_sensor_decoder_unit_test;
  import mpsd_pkg::*;

  localparam int unsigned TICKS_PER_US = 10;
  localparam int PIPE_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int PRINT_LIMIT = 40;
  localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

  typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

  typedef struct packed {
    channel_t    ch;
    logic [31:0] width_us;
    logic [31:0] cycle_us;
    logic [31:0] packet;
  } reading_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TS_W-1:0]      s_axis_tdata;   // timestamp
  logic [0:0]           s_axis_tuser;   // edge_rising
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;   // width_us, period_us_out, packet_number
  logic [CH_W-1:0]      m_axis_tuser;   // channel
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  multiplexed_pwm_sensor_decoder_unit #(
    .TICKS_PER_US(TICKS_PER_US)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Decoder model state and its copy of the configuration.
  logic [WIN_W-1:0] window_reg [0:5];
  logic [31:0]      packet_limit;
  logic [31:0]      last_rise_ts;
  logic [31:0]      held_width_us;
  logic [31:0]      packet_count;
  channel_t         slot;
  bit               locked;
  reading_t         readings_due[$];

  // Stimulus and handshake bookkeeping.
  logic [31:0] line_ts;
  int          burst_left;
  bit          idle_sender;
  ready_mode_t ready_mode;
  int unsigned ready_tick;
  int          holdoff_asked;
  int          holdoff_taken;
  int          holdoff_left;
  int          mismatches;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit win_hit(logic [31:0] v, logic [WIN_W-1:0] w);
    return (v > w[31:0]) && (v < w[63:32]);
  endfunction

  function automatic logic [WIN_W-1:0] window_of(logic [31:0] lo, logic [31:0] hi);
    return {hi, lo};
  endfunction

  function automatic logic [31:0] pick_us(logic [31:0] lo, logic [31:0] hi, bit good);
    if (good) return $urandom_range(lo + 1, hi - 1);
    if (lo > 0 && $urandom_range(0, 1) == 1) return $urandom_range(0, lo);
    return $urandom_range(hi, hi + 40);
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < 6; i++) window_reg[i] = '0;
    packet_limit = WORD_MAX;
    last_rise_ts = '0;
    held_width_us = '0;
    packet_count = '0;
    slot = CH_DIAG;
    locked = 1'b0;
  endtask

  task automatic predict_edge(bit rising, logic [31:0] ts);
    logic [31:0] elapsed_us;
    reading_t    r;
    bit          hit;
    elapsed_us = (ts - last_rise_ts) / TICKS_PER_US;
    if (!rising) begin
      held_width_us = elapsed_us;
      return;
    end
    hit = 1'b0;
    r.ch = slot;
    if (win_hit(elapsed_us, window_reg[CFG_DIAG_PERIOD])) begin
      slot = CH_DIAG;
      locked = 1'b1;
    end
    if (locked) begin
      case (slot)
        CH_DIAG: hit = win_hit(elapsed_us, window_reg[CFG_DIAG_PERIOD]) &&
                       win_hit(held_width_us, window_reg[CFG_DIAG_WIDTH]);
        CH_TEMP: hit = win_hit(elapsed_us, window_reg[CFG_TEMP_PERIOD]) &&
                       win_hit(held_width_us, window_reg[CFG_TEMP_WIDTH]);
        CH_PRESS: begin
          hit = win_hit(elapsed_us, window_reg[CFG_PRESS_PERIOD]) &&
                win_hit(held_width_us, window_reg[CFG_PRESS_WIDTH]);
          if (hit) begin
            packet_count = packet_count + 1;
            if (packet_count > packet_limit) packet_count = '0;
          end
        end
        default: hit = 1'b0;
      endcase
      if (hit) begin
        r.ch = slot;
        r.width_us = held_width_us;
        r.cycle_us = elapsed_us;
        r.packet = packet_count;
        readings_due.push_back(r);
      end
      slot = channel_t'((int'(slot) + 1) % 3);
    end
    last_rise_ts = ts;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // One edge capture; with idle_sender set, the sender idles between bursts of random length.
  task automatic send_edge(bit rising, logic [31:0] ts);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if (idle_sender) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = ts;
    s_axis_tuser = rising;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_edge(rising, ts);
    burst_left--;
    @(negedge clk);
  endtask

  // A pulse is a falling edge after width_us and the next rising edge after cycle_us.
  task automatic send_pulse(logic [31:0] width_us, logic [31:0] cycle_us);
    logic [31:0] rise_ts;
    send_edge(1'b0, line_ts + width_us * TICKS_PER_US + $urandom_range(0, 9));
    rise_ts = line_ts + cycle_us * TICKS_PER_US + $urandom_range(0, 9);
    send_edge(1'b1, rise_ts);
    line_ts = rise_ts;
  endtask

  // A falling edge produces nothing, so the pipeline gets extra cycles after the last result.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_PKT_LIMIT) packet_limit = value[31:0];
    else window_reg[idx] = value;
  endtask

  task automatic load_config(logic [WIN_W-1:0] dp, logic [WIN_W-1:0] dw,
                             logic [WIN_W-1:0] tp, logic [WIN_W-1:0] tw,
                             logic [WIN_W-1:0] pp, logic [WIN_W-1:0] pw,
                             logic [31:0] limit);
    settle();
    write_reg(CFG_DIAG_PERIOD, dp);
    write_reg(CFG_DIAG_WIDTH, dw);
    write_reg(CFG_TEMP_PERIOD, tp);
    write_reg(CFG_TEMP_WIDTH, tw);
    write_reg(CFG_PRESS_PERIOD, pp);
    write_reg(CFG_PRESS_WIDTH, pw);
    write_reg(CFG_PKT_LIMIT, {32'd0, limit});
  endtask

  // With the reset windows nothing can sync, whatever the timestamps.
  task automatic test_unsynced_edges();
    idle_sender = 1'b1;
    ready_mode = READY_RANDOM;
    send_edge(1'b1, 32'h0000_0000);
    send_edge(1'b0, WORD_MAX);
    send_edge(1'b1, WORD_MAX);
    send_edge(1'b0, 32'h0000_0000);
    send_edge(1'b1, 32'h0000_2710);
    line_ts = 32'h0000_2710;
  endtask

  task automatic test_frame_decode();
    load_config(window_of(900, 1100), window_of(400, 600),
                window_of(1900, 2100), window_of(100, 1800),
                window_of(2900, 3100), window_of(100, 2800), 32'd2);
    send_pulse(500, 1000);
    send_pulse(1000, 2000);
    send_pulse(1500, 3000);
    // Values one inside each bound pass; values on a bound are rejected.
    send_pulse(401, 1099);
    send_pulse(100, 2000);
    send_pulse(2799, 2901);
    send_pulse(600, 1000);
    send_pulse(1799, 1901);
    // Third pressure packet exceeds the limit of two, so the counter clears.
    send_pulse(101, 3099);
    // A frame that runs across the timer wrap.
    send_edge(1'b1, 32'hFFFF_F000);
    line_ts = 32'hFFFF_F000;
    send_pulse(500, 1000);
    send_pulse(1000, 2000);
  endtask

  task automatic test_window_extremes();
    logic [31:0] far_ts;
    load_config(window_of(0, WORD_MAX), window_of(0, WORD_MAX),
                window_of(0, WORD_MAX), window_of(0, WORD_MAX),
                window_of(0, WORD_MAX), window_of(0, WORD_MAX), 32'd0);
    send_pulse(0, 1);
    send_pulse(5, 7);
    send_edge(1'b0, line_ts + 32'hF000_0000);
    far_ts = line_ts + 32'hFFFF_FFF0;
    send_edge(1'b1, far_ts);
    line_ts = far_ts;
    // A zero period cannot resync, and it misses the temperature window.
    send_edge(1'b1, line_ts);
    send_pulse(3, 20);
    send_pulse(3, 20);
    load_config(window_of(999, 1001), window_of(0, WORD_MAX),
                window_of(1999, 2001), window_of(0, WORD_MAX),
                window_of(2999, 3001), window_of(0, 0), WORD_MAX);
    send_pulse(10, 1000);
    send_pulse(10, 2000);
    send_pulse(10, 3000);
    send_pulse(10, 1001);
  endtask

  task automatic test_random_frames();
    logic [31:0] lo_us [0:5];
    logic [31:0] hi_us [0:5];
    logic [31:0] noise_ts;
    logic [31:0] limit;
    int          items;
    bit          good;
    for (int phase = 0; phase < 5; phase++) begin
      lo_us[0] = $urandom_range(20, 300);
      hi_us[0] = lo_us[0] + $urandom_range(2, 60);
      lo_us[2] = hi_us[0] + $urandom_range(0, 100);
      hi_us[2] = lo_us[2] + $urandom_range(2, 60);
      lo_us[4] = hi_us[2] + $urandom_range(0, 100);
      hi_us[4] = lo_us[4] + $urandom_range(2, 60);
      for (int k = 1; k < 6; k += 2) begin
        lo_us[k] = $urandom_range(0, 20);
        hi_us[k] = lo_us[k] + $urandom_range(2, 200);
      end
      limit = ($urandom_range(0, 3) == 0) ? WORD_MAX : 32'($urandom_range(0, 4));
      load_config(window_of(lo_us[0], hi_us[0]), window_of(lo_us[1], hi_us[1]),
                  window_of(lo_us[2], hi_us[2]), window_of(lo_us[3], hi_us[3]),
                  window_of(lo_us[4], hi_us[4]), window_of(lo_us[5], hi_us[5]), limit);
      // The first phase runs with no idling on either side.
      idle_sender = (phase != 0);
      ready_mode = (phase == 0) ? READY_ALWAYS : ready_mode_t'(phase % 3);
      items = 0;
      while (items < 70) begin
        if ($urandom_range(0, 9) == 0) begin
          noise_ts = $urandom;
          if ($urandom_range(0, 1) == 1) begin
            send_edge(1'b1, noise_ts);
            line_ts = noise_ts;
          end else begin
            send_edge(1'b0, noise_ts);
          end
          items++;
        end else begin
          for (int k = 0; k < 3; k++) begin
            good = (k == 0) || ($urandom_range(0, 6) != 0);
            send_pulse(pick_us(lo_us[2*k+1], hi_us[2*k+1], $urandom_range(0, 6) != 0),
                       pick_us(lo_us[2*k], hi_us[2*k], good));
          end
          items += 6;
        end
      end
    end
  endtask

  // The receiver holds off while edges keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    load_config(window_of(0, WORD_MAX), window_of(0, WORD_MAX),
                window_of(0, WORD_MAX), window_of(0, WORD_MAX),
                window_of(0, WORD_MAX), window_of(0, WORD_MAX), 32'd3);
    idle_sender = 1'b0;
    ready_mode = READY_ALWAYS;
    holdoff_asked++;
    for (int i = 0; i < 20; i++) send_pulse($urandom_range(1, 500), $urandom_range(1, 5000));
  endtask

  // Result receiver with its own stall pattern and an occasional long hold-off.
  initial begin
    m_axis_tready = 1'b0;
    holdoff_taken = 0;
    holdoff_left = 0;
    ready_tick = 0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        m_axis_tready = 1'b0;
        holdoff_left--;
      end else if (holdoff_asked != holdoff_taken) begin
        holdoff_taken = holdoff_asked;
        holdoff_left = HOLDOFF_CYCLES - 1;
        m_axis_tready = 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS: m_axis_tready = 1'b1;
          READY_RANDOM: m_axis_tready = ($urandom_range(0, 3) != 0);
          default:      m_axis_tready = ((ready_tick % 9) < 5);
        endcase
      end
      ready_tick++;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (readings_due.size() == 0) begin
        report_mismatch("result with nothing expected, channel", 32'(m_axis_tuser), '0);
      end else begin
        want = readings_due.pop_front();
        if (m_axis_tuser != want.ch)
          report_mismatch("channel", 32'(m_axis_tuser), 32'(want.ch));
        if (m_axis_tdata[31:0] != want.width_us)
          report_mismatch("width_us", m_axis_tdata[31:0], want.width_us);
        if (m_axis_tdata[63:32] != want.cycle_us)
          report_mismatch("period_us_out", m_axis_tdata[63:32], want.cycle_us);
        if (m_axis_tdata[95:64] != want.packet)
          report_mismatch("packet_number", m_axis_tdata[95:64], want.packet);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multiplexed_pwm_sensor_decoder_unit test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DIAG_PERIOD;
    cfg_data = '0;
    line_ts = '0;
    burst_left = 0;
    idle_sender = 1'b1;
    ready_mode = READY_ALWAYS;
    holdoff_asked = 0;
    mismatches = 0;
    quiet_cycles = 0;
    reset_predictor();
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_unsynced_edges();
    test_frame_decode();
    test_window_extremes();
    test_random_frames();
    test_output_backpressure();
    settle();
    if (mismatches == 0)
      $display("multiplexed_pwm_sensor_decoder_unit test passed");
    else
      $display("multiplexed_pwm_sensor_decoder_unit test failed");
    $finish;
  end

endmodule
